@@ hdl/tti_pkg.sv @@
`timescale 1ns / 1ps

package tti_pkg;

    // Sizes of the index datapath.
    localparam int DIMS        = 6;
    localparam int MAX_DIMS    = 6;
    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 32;

    // Register field widths, fixed by the register layout.
    localparam int FIELD_BITS      = 16;
    localparam int LOG2_BITS       = 4;
    localparam int SHIFT_BITS      = 5;
    localparam int TILE_ELEMS_BITS = 16;
    localparam int CFG_DATA_BITS   = 48;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int FIELDS_PER_REG  = 3;

    // Origin plus coordinate is kept without loss.
    localparam int POS_BITS  = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 1;
    localparam int PROD_BITS = POS_BITS + FIELD_BITS;
    localparam int SCALE_BITS = INDEX_BITS + TILE_ELEMS_BITS;

    // Depth of the beat pipeline: the dimension cells, then the multiply and add stages.
    localparam int LATENCY = DIMS + 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TILE_LOG2     = 3'd0,
        REG_IN_TILE_SHIFT = 3'd1,
        REG_STRIDE_NXY    = 3'd2,
        REG_STRIDE_ZPQ    = 3'd3,
        REG_VIEW_NXY      = 3'd4,
        REG_VIEW_ZPQ      = 3'd5,
        REG_TILE_ELEMS    = 3'd6
    } t_reg_index;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Settings that one dimension cell needs.
    typedef struct packed {
        logic [FIELD_BITS-1:0] origin;
        logic [FIELD_BITS-1:0] stride;
        logic [LOG2_BITS-1:0]  lg;
        logic [SHIFT_BITS-1:0] sh;
    } t_dim_cfg;

    // Partial result handed from cell to cell. The pending coordinates
    // move down by one place in every cell, so each cell reads entry 0.
    typedef struct packed {
        t_coord [MAX_DIMS-1:0]  coords;
        logic [INDEX_BITS-1:0]  offset;
        logic [INDEX_BITS-1:0]  tile_num;
    } t_beat;

    // Pipeline control handed to every stage.
    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

endpackage

@@ hdl/tti_cell.sv @@
`timescale 1ns / 1ps

module tti_cell import tti_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ctl     i_ctl,
    input  t_beat    i_beat,
    input  t_dim_cfg i_cfg,
    output logic     o_valid,
    output t_beat    o_beat
);

    logic                  r_valid;
    t_beat                 r_beat;
    t_beat                 n_beat;
    logic [POS_BITS-1:0]   w_pos;
    logic [POS_BITS-1:0]   w_mask;
    logic [POS_BITS-1:0]   w_inner;
    logic [POS_BITS-1:0]   w_tcoord;
    logic [INDEX_BITS-1:0] w_placed;
    logic [PROD_BITS-1:0]  w_prod;

    // Split the absolute position into tile coordinate and in-tile index.
    always_comb begin
        w_pos    = POS_BITS'(i_beat.coords[0]) + POS_BITS'(i_cfg.origin);
        w_mask   = (POS_BITS'(1) << i_cfg.lg) - POS_BITS'(1);
        w_inner  = w_pos & w_mask;
        w_tcoord = w_pos >> i_cfg.lg;
        w_placed = INDEX_BITS'(w_inner) << i_cfg.sh;
        w_prod   = PROD_BITS'(w_tcoord) * PROD_BITS'(i_cfg.stride);
    end

    // Fold this dimension into the running offset and tile number.
    always_comb begin
        for (int i = 0; i < MAX_DIMS - 1; i++) begin
            n_beat.coords[i] = i_beat.coords[i+1];
        end
        n_beat.coords[MAX_DIMS-1] = '0;
        n_beat.offset   = i_beat.offset | w_placed;
        n_beat.tile_num = i_beat.tile_num + INDEX_BITS'(w_prod);
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

@@ hdl/tti_scale.sv @@
`timescale 1ns / 1ps

module tti_scale import tti_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    input  t_beat                      i_beat,
    input  logic [TILE_ELEMS_BITS-1:0] i_tile_elems,
    output logic                       o_valid,
    output logic [INDEX_BITS-1:0]      o_index
);

    logic                  r_mul_valid;
    logic [INDEX_BITS-1:0] r_mul_prod;
    logic [INDEX_BITS-1:0] r_mul_offset;
    logic [INDEX_BITS-1:0] n_mul_prod;
    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_index;
    logic [INDEX_BITS-1:0] n_out_index;
    logic [SCALE_BITS-1:0] w_full;

    // Tile number times tile size, then add the in-tile offset.
    always_comb begin
        w_full      = SCALE_BITS'(i_beat.tile_num) * SCALE_BITS'(i_tile_elems);
        n_mul_prod  = INDEX_BITS'(w_full);
        n_out_index = r_mul_offset + r_mul_prod;
    end

    // Valid bits of the multiply and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_mul_valid <= i_ctl.valid;
            r_out_valid <= r_mul_valid;
        end
    end

    // Payload of the multiply and output stages.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_mul_prod   <= n_mul_prod;
            r_mul_offset <= i_beat.offset;
            r_out_index  <= n_out_index;
        end
    end

    assign o_valid = r_out_valid;
    assign o_index = r_out_index;

endmodule

@@ hdl/tiled_tensor_index_calc.sv @@
`timescale 1ns / 1ps
// Pipeline: an accepted input beat passes one cell per dimension, then one multiply
// stage and one add stage, on its way to its output beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat waits.
// Reset (synchronous, active low) empties the pipeline and sets every configuration
// register to 0, except tile_elems, which becomes 1.

module tiled_tensor_index_calc import tti_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input beats.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // coord_n, coord_x, coord_y, coord_z, coord_p, coord_q (16 bits each)
    input  logic [MAX_DIMS*COORD_BITS-1:0] s_axis_tdata,
    // Output beats.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // elem_index (32 bits)
    output logic [INDEX_BITS-1:0]       m_axis_tdata,
    // Register writes.
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [MAX_DIMS*LOG2_BITS-1:0]       r_tile_log2;
    logic [MAX_DIMS*SHIFT_BITS-1:0]      r_in_tile_shift;
    logic [FIELDS_PER_REG*FIELD_BITS-1:0] r_stride_nxy;
    logic [FIELDS_PER_REG*FIELD_BITS-1:0] r_stride_zpq;
    logic [FIELDS_PER_REG*FIELD_BITS-1:0] r_view_nxy;
    logic [FIELDS_PER_REG*FIELD_BITS-1:0] r_view_zpq;
    logic [TILE_ELEMS_BITS-1:0]          r_tile_elems;

    logic     w_en;
    logic     w_valid [DIMS+1];
    t_beat    w_beat  [DIMS+1];
    t_dim_cfg w_dim_cfg [DIMS];
    t_ctl     w_ctl   [DIMS+1];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_log2     <= '0;
            r_in_tile_shift <= '0;
            r_stride_nxy    <= '0;
            r_stride_zpq    <= '0;
            r_view_nxy      <= '0;
            r_view_zpq      <= '0;
            r_tile_elems    <= TILE_ELEMS_BITS'(1);
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_TILE_LOG2: begin
                    r_tile_log2 <= i_cfg_data[MAX_DIMS*LOG2_BITS-1:0];
                end
                REG_IN_TILE_SHIFT: begin
                    r_in_tile_shift <= i_cfg_data[MAX_DIMS*SHIFT_BITS-1:0];
                end
                REG_STRIDE_NXY: begin
                    r_stride_nxy <= i_cfg_data[FIELDS_PER_REG*FIELD_BITS-1:0];
                end
                REG_STRIDE_ZPQ: begin
                    r_stride_zpq <= i_cfg_data[FIELDS_PER_REG*FIELD_BITS-1:0];
                end
                REG_VIEW_NXY: begin
                    r_view_nxy <= i_cfg_data[FIELDS_PER_REG*FIELD_BITS-1:0];
                end
                REG_VIEW_ZPQ: begin
                    r_view_zpq <= i_cfg_data[FIELDS_PER_REG*FIELD_BITS-1:0];
                end
                REG_TILE_ELEMS: begin
                    r_tile_elems <= i_cfg_data[TILE_ELEMS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being drained.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // Entry into the cell chain: coordinates unpacked, sums cleared.
    always_comb begin
        for (int i = 0; i < MAX_DIMS; i++) begin
            w_beat[0].coords[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        end
        w_beat[0].offset   = '0;
        w_beat[0].tile_num = '0;
        w_valid[0]         = s_axis_tvalid;
    end

    // One cell per dimension, each with its own slice of the registers.
    for (genvar d = 0; d < DIMS; d++) begin : g_cell
        if (d < FIELDS_PER_REG) begin : g_lo
            assign w_dim_cfg[d].origin = r_view_nxy[d*FIELD_BITS +: FIELD_BITS];
            assign w_dim_cfg[d].stride = r_stride_nxy[d*FIELD_BITS +: FIELD_BITS];
        end else begin : g_hi
            assign w_dim_cfg[d].origin =
                r_view_zpq[(d-FIELDS_PER_REG)*FIELD_BITS +: FIELD_BITS];
            assign w_dim_cfg[d].stride =
                r_stride_zpq[(d-FIELDS_PER_REG)*FIELD_BITS +: FIELD_BITS];
        end
        assign w_dim_cfg[d].lg = r_tile_log2[d*LOG2_BITS +: LOG2_BITS];
        assign w_dim_cfg[d].sh = r_in_tile_shift[d*SHIFT_BITS +: SHIFT_BITS];
        assign w_ctl[d]        = '{en: w_en, valid: w_valid[d]};

        tti_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[d]),
            .i_beat  (w_beat[d]),
            .i_cfg   (w_dim_cfg[d]),
            .o_valid (w_valid[d+1]),
            .o_beat  (w_beat[d+1])
        );
    end

    assign w_ctl[DIMS] = '{en: w_en, valid: w_valid[DIMS]};

    // Scale by the tile size and form the final index.
    tti_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl[DIMS]),
        .i_beat       (w_beat[DIMS]),
        .i_tile_elems (r_tile_elems),
        .o_valid      (m_axis_tvalid),
        .o_index      (m_axis_tdata)
    );

endmodule

@@ hdl/tti_checker.sv @@
`timescale 1ns / 1ps

module tti_checker import tti_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [INDEX_BITS-1:0] m_axis_tdata
);

    // The cycle after reset shows no output beat.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat present right after reset");

    // A waiting output beat stalls the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output beat is stalled");

    // With no output beat pending the block always takes input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while output register is empty");

    // A stalled output beat keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

endmodule

bind tiled_tensor_index_calc tti_checker u_tti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
